// ===== rtl/ikr_pkg.sv =====
// ----------------------------------------------------------------------------
// ikr_pkg
// Shared types and constants for the integer k-th root block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ikr_pkg;

   localparam int ROOT_BITS = 32;
   localparam int POS_W     = $clog2(ROOT_BITS);
   localparam int RAD_W     = 64;
   localparam int EXP_W     = 7;
   localparam int OUT_W     = 32;
   localparam int MUL_W     = 32;

   localparam logic [EXP_W-1:0] EXP_CLAMP = EXP_W'(64);
   localparam logic [POS_W-1:0] POS_TOP   = POS_W'(ROOT_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_TEST,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_COMBINE,
      ST_DECIDE,
      ST_DONE
   } ikr_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // latch a new beat, clear root
      logic init;      // form candidate, acc = candidate
      logic mul_lo;    // low half of acc times candidate
      logic mul_hi;    // high half of acc times candidate
      logic step;      // acc takes the product, one multiplication fewer left
      logic decide;    // keep candidate bit if its power fits
      logic next_pos;  // move to the next lower root bit
   } ikr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic exp_zero;  // incoming exponent is zero
      logic left_zero; // no multiplications left for this candidate
      logic overflow;  // product does not fit in 64 bits
      logic pos_zero;  // working on bit 0
   } ikr_stat_type;

endpackage

`default_nettype wire

// ===== rtl/ikr_datapath.sv =====
// ----------------------------------------------------------------------------
// ikr_datapath
// Root, candidate and power registers around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ikr_datapath (
   input  wire logic                        clock,
   input  wire ikr_pkg::ikr_cmd_type        cmd,
   output ikr_pkg::ikr_stat_type            stat,
   input  wire logic [ikr_pkg::RAD_W-1:0]   req_radicand,
   input  wire logic [ikr_pkg::EXP_W-1:0]   req_exponent,
   output logic      [ikr_pkg::OUT_W-1:0]   rsp_root,
   output logic                             rsp_bad_exponent
);
   import ikr_pkg::*;

   logic [RAD_W-1:0]     radicand_ff, radicand_in;
   logic [EXP_W-1:0]     k_ff, k_in;
   logic [EXP_W-1:0]     left_ff, left_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [ROOT_BITS-1:0] cand_ff, cand_in;
   logic [RAD_W-1:0]     acc_ff, acc_in;
   logic [2*MUL_W-1:0]   plo_ff, plo_in;
   logic [2*MUL_W-1:0]   phi_ff, phi_in;
   logic                 bad_ff, bad_in;

   logic [ROOT_BITS-1:0] cand_next;
   logic [MUL_W-1:0]     mul_a;
   logic [2*MUL_W-1:0]   product;
   logic [MUL_W:0]       mid_sum;

   assign cand_next = root_ff | (ROOT_BITS'(1) << pos_ff);

   // one multiplier, fed the low or the high half of acc
   assign mul_a   = cmd.mul_hi ? acc_ff[RAD_W-1:MUL_W] : acc_ff[MUL_W-1:0];
   assign product = mul_a * MUL_W'(cand_ff);

   // full product is phi << 32 + plo; it fits only without carry past bit 63
   assign mid_sum = {1'b0, phi_ff[MUL_W-1:0]} + {1'b0, plo_ff[2*MUL_W-1:MUL_W]};

   always_comb begin
      radicand_in = radicand_ff;
      k_in        = k_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      root_in     = root_ff;
      cand_in     = cand_ff;
      acc_in      = acc_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      bad_in      = bad_ff;
      if (cmd.load) begin
         radicand_in = req_radicand;
         k_in        = (req_exponent > EXP_CLAMP) ? EXP_CLAMP : req_exponent;
         pos_in      = POS_TOP;
         root_in     = '0;
         bad_in      = (req_exponent == '0);
      end
      if (cmd.init) begin
         cand_in = cand_next;
         acc_in  = RAD_W'(cand_next);
         left_in = k_ff - EXP_W'(1);
      end
      if (cmd.mul_lo) begin
         plo_in = product;
      end
      if (cmd.mul_hi) begin
         phi_in = product;
      end
      if (cmd.step) begin
         acc_in  = {mid_sum[MUL_W-1:0], plo_ff[MUL_W-1:0]};
         left_in = left_ff - EXP_W'(1);
      end
      if (cmd.decide && (acc_ff <= radicand_ff)) begin
         root_in = cand_ff;
      end
      if (cmd.next_pos) begin
         pos_in = pos_ff - POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      radicand_ff <= radicand_in;
      k_ff        <= k_in;
      left_ff     <= left_in;
      pos_ff      <= pos_in;
      root_ff     <= root_in;
      cand_ff     <= cand_in;
      acc_ff      <= acc_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      bad_ff      <= bad_in;
   end

   assign stat.exp_zero  = (req_exponent == '0);
   assign stat.left_zero = (left_ff == '0);
   assign stat.overflow  = (|phi_ff[2*MUL_W-1:MUL_W]) | mid_sum[MUL_W];
   assign stat.pos_zero  = (pos_ff == '0);

   assign rsp_root         = OUT_W'(root_ff);
   assign rsp_bad_exponent = bad_ff;

endmodule

`default_nettype wire

// ===== rtl/ikr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ikr_ctrl
// Sequencer: walks root bits, and multiplications per candidate bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ikr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       done,
   output ikr_pkg::ikr_cmd_type       cmd,
   input  wire ikr_pkg::ikr_stat_type stat
);
   import ikr_pkg::*;

   ikr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.exp_zero ? ST_DONE : ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            state_in = stat.left_zero ? ST_DECIDE : ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.step = 1'b1;
            if (!stat.overflow) begin
               state_in = ST_TEST;
            end else if (stat.pos_zero) begin
               // candidate rejected on overflow
               state_in = ST_DONE;
            end else begin
               cmd.next_pos = 1'b1;
               state_in     = ST_INIT;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.pos_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.next_pos = 1'b1;
               state_in     = ST_INIT;
            end
         end
         ST_DONE: begin
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/integer_kth_root_64.sv =====
// ----------------------------------------------------------------------------
// integer_kth_root_64
// Floor of the k-th root of a 64-bit unsigned value, one root bit at a time.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  request  | start, busy            | req_radicand[63:0], req_exponent[6:0]
//  response | rsp_valid (1-cycle)    | rsp_root[31:0], rsp_bad_exponent
//
//  A beat is taken when start is high and busy is low; busy then holds until
//  the response strobe. Each root bit steps through INIT and TEST, then
//  MUL_LO, MUL_HI, COMBINE and TEST per multiplication (at most k-1 of
//  them), then DECIDE when the power fits; an overflow in COMBINE skips
//  DECIDE. One 32x32 multiplier is used twice per 64x32 multiplication.
//  A zero exponent goes straight from IDLE to DONE.
//  Reset is synchronous and returns the sequencer to idle. The receiver
//  cannot stall: the response is on the ports for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_kth_root_64 (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [ikr_pkg::RAD_W-1:0] req_radicand,
   input  wire logic [ikr_pkg::EXP_W-1:0] req_exponent,
   output logic                           rsp_valid,
   output logic      [ikr_pkg::OUT_W-1:0] rsp_root,
   output logic                           rsp_bad_exponent
);
   import ikr_pkg::*;

   ikr_cmd_type  cmd;
   ikr_stat_type stat;

   ikr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .done  (rsp_valid),
      .cmd   (cmd),
      .stat  (stat)
   );

   ikr_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .stat             (stat),
      .req_radicand     (req_radicand),
      .req_exponent     (req_exponent),
      .rsp_root         (rsp_root),
      .rsp_bad_exponent (rsp_bad_exponent)
   );

   a_valid_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe outside a busy period");

   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_exponent) |-> (rsp_root == '0))
      else $error("zero exponent with nonzero root");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start work");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

endmodule

`default_nettype wire
